[design/rmc_pkg.sv]
package rmc_pkg;

    localparam logic [4:0] MaxFieldChars = 5'd15;
    localparam logic [3:0] MaxFieldNumber = 4'd15;

    localparam logic [2:0] HdrIdle = 3'd0;
    localparam logic [2:0] HdrInside = 3'd6;

    localparam logic [7:0] ChDollar = 8'h24;
    localparam logic [7:0] ChStar = 8'h2a;
    localparam logic [7:0] ChCr = 8'h0d;
    localparam logic [7:0] ChLf = 8'h0a;
    localparam logic [7:0] ChComma = 8'h2c;
    localparam logic [7:0] ChDot = 8'h2e;

    localparam logic [31:0] LatMax = 32'd162000000;
    localparam logic [31:0] LonMax = 32'd324000000;
    localparam logic [27:0] SpeedMax = 28'hffffff;
    localparam logic [12:0] CourseMax = 13'd511;

    localparam logic [9:0] ScaleReset = 10'd185;
    localparam logic AddrScale = 1'b0;

    // 2^42 / 100000 rounded up; exact for products below 256 * 100000.
    localparam logic [25:0] RecipSpeed = 26'd43980466;
    localparam logic [33:0] SpeedSatLimit = 34'd25600000;

    typedef struct packed {
        logic               fix;
        logic [11:0][3:0]   digits;
        logic signed [28:0] lat;
        logic signed [29:0] lon;
        logic [23:0]        speed_th;
        logic [8:0]         course;
    } snap_t;

    function automatic logic [7:0] hdr_char(input logic [2:0] pos);
        case (pos)
            3'd1: hdr_char = 8'h47;
            3'd2: hdr_char = 8'h50;
            3'd3: hdr_char = 8'h52;
            3'd4: hdr_char = 8'h4d;
            3'd5: hdr_char = 8'h43;
            default: hdr_char = ChDollar;
        endcase
    endfunction

    function automatic logic [27:0] lat_weight(input logic [3:0] k);
        case (k)
            4'd0: lat_weight = 28'd18000000;
            4'd1: lat_weight = 28'd1800000;
            4'd2: lat_weight = 28'd300000;
            4'd3: lat_weight = 28'd30000;
            4'd5: lat_weight = 28'd3000;
            4'd6: lat_weight = 28'd300;
            4'd7: lat_weight = 28'd30;
            4'd8: lat_weight = 28'd3;
            default: lat_weight = 28'd0;
        endcase
    endfunction

    function automatic logic [28:0] lon_weight(input logic [3:0] k);
        case (k)
            4'd0: lon_weight = 29'd180000000;
            4'd1: lon_weight = 29'd18000000;
            4'd2: lon_weight = 29'd1800000;
            4'd3: lon_weight = 29'd300000;
            4'd4: lon_weight = 29'd30000;
            4'd6: lon_weight = 29'd3000;
            4'd7: lon_weight = 29'd300;
            4'd8: lon_weight = 29'd30;
            4'd9: lon_weight = 29'd3;
            default: lon_weight = 29'd0;
        endcase
    endfunction

    function automatic logic [6:0] frac_weight(input logic [2:0] phase);
        case (phase)
            3'd1: frac_weight = 7'd100;
            3'd2: frac_weight = 7'd10;
            3'd3: frac_weight = 7'd1;
            default: frac_weight = 7'd0;
        endcase
    endfunction

    // Day of a March-based year on which month m begins.
    function automatic logic [8:0] doy_of_month(input logic [3:0] m);
        case (m)
            4'd1: doy_of_month = 9'd306;
            4'd2: doy_of_month = 9'd337;
            4'd3: doy_of_month = 9'd0;
            4'd4: doy_of_month = 9'd31;
            4'd5: doy_of_month = 9'd61;
            4'd6: doy_of_month = 9'd92;
            4'd7: doy_of_month = 9'd122;
            4'd8: doy_of_month = 9'd153;
            4'd9: doy_of_month = 9'd184;
            4'd10: doy_of_month = 9'd214;
            4'd11: doy_of_month = 9'd245;
            4'd12: doy_of_month = 9'd275;
            default: doy_of_month = 9'd0;
        endcase
    endfunction

endpackage

[design/nmea_rmc_sentence_parser.sv]
// RMC sentence parser. One received character enters per beat on the s_ channel,
// and a beat can be taken in every cycle unless a result waits on m_ready. A
// sentence that opens with the header "$GPRMC" is split into its comma-separated
// fields; time, status, latitude and its hemisphere, longitude and its hemisphere,
// speed in knots, course and date are gathered character by character. When the
// sentence ends ('*', CR or LF) one result beat is produced on the m_ channel via
// the snapshot, stage two, stage three and output registers. The result holds a
// fix flag, UTC seconds since 1970 (years read as 2000 onwards, out-of-range date
// and time parts carried), latitude and longitude in 1/30000 arc minute (negative
// for south and west; a missing hemisphere repeats the previous position), speed
// in km/h saturated at 255, and the whole degrees of course. A sentence whose
// status is not 'A' or 'a' gives a result with the fix flag low and all other
// fields zero. In the conversion pipeline the speed multiply, the day count and
// the seconds multiply each have a register stage of their own.
// The whole pipeline stalls only while a finished result waits on m_ready.
// The checksum is not checked. Register 0 at byte address 0 holds the knots to
// km/h factor in hundredths (reset 185); write it only while the block is idle.
module nmea_rmc_sentence_parser (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_fix_valid,
    output logic [31:0] m_utc_seconds,
    output logic signed [28:0] m_latitude_units,
    output logic signed [29:0] m_longitude_units,
    output logic [7:0]  m_speed_kmh,
    output logic [8:0]  m_course_degrees,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rmc_pkg::*;

    logic           advance;
    logic           accept;
    logic           snap_valid;
    snap_t          snap;
    logic [9:0]     scale_reg, scale_next;

    // Every stage moves on together whenever the result register is free or being
    // emptied, so a new beat is taken even while a result is on its way out.
    assign advance = !m_valid || m_ready;
    assign s_ready = advance;
    assign accept = s_valid && s_ready;

    // Configuration port: a single register, written in the access phase.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == AddrScale) ? {22'd0, scale_reg} : 32'd0;

    always_comb begin
        scale_next = scale_reg;
        if (psel && penable && pwrite && pready && paddr[2] == AddrScale) begin
            scale_next = pwdata[9:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= ScaleReset;
        end else begin
            scale_reg <= scale_next;
        end
    end

    rmc_lexer u_lexer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .advance    (advance),
        .rx_byte    (s_rx_byte),
        .snap_valid (snap_valid),
        .snap       (snap)
    );

    rmc_convert u_convert (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .advance         (advance),
        .snap_valid      (snap_valid),
        .snap            (snap),
        .scale           (scale_reg),
        .out_valid       (m_valid),
        .fix_valid       (m_fix_valid),
        .utc_seconds     (m_utc_seconds),
        .latitude_units  (m_latitude_units),
        .longitude_units (m_longitude_units),
        .speed_kmh       (m_speed_kmh),
        .course_degrees  (m_course_degrees)
    );

endmodule

[design/rmc_lexer.sv]
module rmc_lexer (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          accept,
    input  logic          advance,
    input  logic [7:0]    rx_byte,
    output logic          snap_valid,
    output rmc_pkg::snap_t snap
);
    import rmc_pkg::*;

    logic [2:0]       hdr_reg, hdr_next;
    logic [3:0]       fn_reg, fn_next;
    logic [4:0]       cif_reg, cif_next;
    logic [2:0]       dot_reg, dot_next;
    logic             status_reg, status_next;
    logic [11:0][3:0] dig_reg, dig_next;
    logic [28:0]      lat_acc_reg, lat_acc_next;
    logic [29:0]      lon_acc_reg, lon_acc_next;
    logic [3:0]       hem_reg, hem_next;
    logic signed [28:0] last_lat_reg, last_lat_next;
    logic signed [29:0] last_lon_reg, last_lon_next;
    logic [23:0]      spd_reg, spd_next;
    logic [8:0]       crs_reg, crs_next;
    logic             sv_reg, sv_next;
    snap_t            snap_reg, snap_next;

    logic        is_digit;
    logic [3:0]  dval;
    logic [31:0] lat_sum, lon_sum;
    logic [27:0] spd_int, spd_frac;
    logic [12:0] crs_sum;
    logic        term;

    assign is_digit = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
    assign dval = is_digit ? rx_byte[3:0] : 4'd0;
    assign term = (rx_byte == ChStar) || (rx_byte == ChCr) || (rx_byte == ChLf);

    assign lat_sum = {3'd0, lat_acc_reg} + 32'(dval) * {4'd0, lat_weight(cif_reg[3:0])};
    assign lon_sum = {2'd0, lon_acc_reg} + 32'(dval) * {3'd0, lon_weight(cif_reg[3:0])};
    assign spd_int = {4'd0, spd_reg} * 28'd10 + 28'(dval) * 28'd1000;
    assign spd_frac = {4'd0, spd_reg} + 28'(dval) * 28'(frac_weight(dot_reg));
    assign crs_sum = {4'd0, crs_reg} * 13'd10 + 13'(dval);

    always_comb begin
        hdr_next = hdr_reg;
        fn_next = fn_reg;
        cif_next = cif_reg;
        dot_next = dot_reg;
        status_next = status_reg;
        dig_next = dig_reg;
        lat_acc_next = lat_acc_reg;
        lon_acc_next = lon_acc_reg;
        hem_next = hem_reg;
        last_lat_next = last_lat_reg;
        last_lon_next = last_lon_reg;
        spd_next = spd_reg;
        crs_next = crs_reg;
        sv_next = advance ? 1'b0 : sv_reg;
        snap_next = snap_reg;
        if (accept) begin
            if (rx_byte == ChDollar) begin
                hdr_next = 3'd1;
            end else if (hdr_reg != HdrInside) begin
                if (hdr_reg != HdrIdle && rx_byte == hdr_char(hdr_reg)) begin
                    hdr_next = hdr_reg + 3'd1;
                    if (hdr_reg == 3'd5) begin
                        fn_next = 4'd0;
                        cif_next = 5'd0;
                        dot_next = 3'd0;
                        status_next = 1'b0;
                        dig_next = '0;
                        lat_acc_next = '0;
                        lon_acc_next = '0;
                        hem_next = 4'd0;
                        spd_next = '0;
                        crs_next = '0;
                    end
                end else begin
                    hdr_next = HdrIdle;
                end
            end else if (term) begin
                hdr_next = HdrIdle;
                if (status_reg) begin
                    if (hem_reg[0]) begin
                        last_lat_next = $signed(lat_acc_reg);
                    end else if (hem_reg[1]) begin
                        last_lat_next = -$signed(lat_acc_reg);
                    end
                    if (hem_reg[2]) begin
                        last_lon_next = $signed(lon_acc_reg);
                    end else if (hem_reg[3]) begin
                        last_lon_next = -$signed(lon_acc_reg);
                    end
                end
                sv_next = 1'b1;
                snap_next.fix = status_reg;
                snap_next.digits = dig_reg;
                snap_next.lat = last_lat_next;
                snap_next.lon = last_lon_next;
                snap_next.speed_th = spd_reg;
                snap_next.course = crs_reg;
            end else if (rx_byte == ChComma) begin
                if (fn_reg != MaxFieldNumber) begin
                    fn_next = fn_reg + 4'd1;
                end
                cif_next = 5'd0;
                dot_next = 3'd0;
            end else if (cif_reg < MaxFieldChars) begin
                cif_next = cif_reg + 5'd1;
                case (fn_reg)
                    4'd1: begin
                        if (cif_reg < 5'd6) begin
                            dig_next[cif_reg[3:0]] = dval;
                        end
                    end
                    4'd2: begin
                        if (cif_reg == 5'd0 && (rx_byte == 8'h41 || rx_byte == 8'h61)) begin
                            status_next = 1'b1;
                        end
                    end
                    4'd3: begin
                        if (is_digit && cif_reg < 5'd9) begin
                            lat_acc_next = (lat_sum > LatMax) ? LatMax[28:0] : lat_sum[28:0];
                        end
                    end
                    4'd4: begin
                        if (cif_reg == 5'd0 && rx_byte == 8'h4e) hem_next[0] = 1'b1;
                        if (cif_reg == 5'd0 && rx_byte == 8'h53) hem_next[1] = 1'b1;
                    end
                    4'd5: begin
                        if (is_digit && cif_reg < 5'd10) begin
                            lon_acc_next = (lon_sum > LonMax) ? LonMax[29:0] : lon_sum[29:0];
                        end
                    end
                    4'd6: begin
                        if (cif_reg == 5'd0 && rx_byte == 8'h45) hem_next[2] = 1'b1;
                        if (cif_reg == 5'd0 && rx_byte == 8'h57) hem_next[3] = 1'b1;
                    end
                    4'd7: begin
                        if (rx_byte == ChDot && dot_reg == 3'd0) begin
                            dot_next = 3'd1;
                        end else if (is_digit) begin
                            if (dot_reg == 3'd0) begin
                                spd_next = (spd_int > SpeedMax) ? SpeedMax[23:0] : spd_int[23:0];
                            end else if (dot_reg < 3'd4) begin
                                spd_next = (spd_frac > SpeedMax) ? SpeedMax[23:0]
                                                                 : spd_frac[23:0];
                                dot_next = dot_reg + 3'd1;
                            end
                        end
                    end
                    4'd8: begin
                        if (rx_byte == ChDot && dot_reg == 3'd0) begin
                            dot_next = 3'd1;
                        end else if (is_digit && dot_reg == 3'd0) begin
                            crs_next = (crs_sum > CourseMax) ? CourseMax[8:0] : crs_sum[8:0];
                        end
                    end
                    4'd9: begin
                        if (cif_reg < 5'd6) begin
                            dig_next[4'd6 + cif_reg[3:0]] = dval;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_reg <= HdrIdle;
            fn_reg <= '0;
            cif_reg <= '0;
            dot_reg <= '0;
            status_reg <= 1'b0;
            dig_reg <= '0;
            lat_acc_reg <= '0;
            lon_acc_reg <= '0;
            hem_reg <= '0;
            last_lat_reg <= '0;
            last_lon_reg <= '0;
            spd_reg <= '0;
            crs_reg <= '0;
            sv_reg <= 1'b0;
        end else begin
            hdr_reg <= hdr_next;
            fn_reg <= fn_next;
            cif_reg <= cif_next;
            dot_reg <= dot_next;
            status_reg <= status_next;
            dig_reg <= dig_next;
            lat_acc_reg <= lat_acc_next;
            lon_acc_reg <= lon_acc_next;
            hem_reg <= hem_next;
            last_lat_reg <= last_lat_next;
            last_lon_reg <= last_lon_next;
            spd_reg <= spd_next;
            crs_reg <= crs_next;
            sv_reg <= sv_next;
        end
    end

    always_ff @(posedge aclk) begin
        snap_reg <= snap_next;
    end

    assign snap_valid = sv_reg;
    assign snap = snap_reg;

    a_hdr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        hdr_reg <= HdrInside) else $error("header position out of range");
    a_cif_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cif_reg <= MaxFieldChars) else $error("field character count overran");
    a_dot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        dot_reg <= 3'd4) else $error("decimal phase out of range");
    a_snap_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        sv_reg && !advance |=> sv_reg && $stable(snap_reg))
        else $error("stalled snapshot changed");

endmodule

[design/rmc_convert.sv]
module rmc_convert (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           advance,
    input  logic           snap_valid,
    input  rmc_pkg::snap_t snap,
    input  logic [9:0]     scale,
    output logic           out_valid,
    output logic           fix_valid,
    output logic [31:0]    utc_seconds,
    output logic signed [28:0] latitude_units,
    output logic signed [29:0] longitude_units,
    output logic [7:0]     speed_kmh,
    output logic [8:0]     course_degrees
);
    import rmc_pkg::*;

    // Stage two: decoded date and time fields, raw speed product.
    logic        v2_reg;
    logic        fix2_reg;
    logic [18:0] tod2_reg;
    logic [8:0]  yoe2_reg;
    logic [8:0]  doy2_reg;
    logic [6:0]  dd2_reg;
    logic [33:0] prod2_reg;
    logic signed [28:0] lat2_reg;
    logic signed [29:0] lon2_reg;
    logic [8:0]  crs2_reg;

    // Stage three: day number and km/h.
    logic        v3_reg;
    logic        fix3_reg;
    logic [18:0] tod3_reg;
    logic [16:0] days3_reg;
    logic [7:0]  kmh3_reg;
    logic signed [28:0] lat3_reg;
    logic signed [29:0] lon3_reg;
    logic [8:0]  crs3_reg;

    logic        vo_reg;
    logic        fixo_reg;
    logic [31:0] utco_reg;
    logic signed [28:0] lato_reg;
    logic signed [29:0] lono_reg;
    logic [7:0]  kmho_reg;
    logic [8:0]  crso_reg;

    logic [6:0]  hh, mi, ss, dd, mo, yy, mon0;
    logic [12:0] q12_prod;
    logic [3:0]  q12;
    logic [3:0]  month;
    logic [8:0]  yoe;
    logic [18:0] tod;
    logic [19:0] days_w;
    logic [2:0]  cent;
    logic [50:0] kmh_prod;
    logic [31:0] secs;

    assign hh = 7'(snap.digits[0]) * 7'd10 + 7'(snap.digits[1]);
    assign mi = 7'(snap.digits[2]) * 7'd10 + 7'(snap.digits[3]);
    assign ss = 7'(snap.digits[4]) * 7'd10 + 7'(snap.digits[5]);
    assign dd = 7'(snap.digits[6]) * 7'd10 + 7'(snap.digits[7]);
    assign mo = 7'(snap.digits[8]) * 7'd10 + 7'(snap.digits[9]);
    assign yy = 7'(snap.digits[10]) * 7'd10 + 7'(snap.digits[11]);

    // Month zero is December of the year before; larger months carry into years.
    assign mon0 = mo - 7'd1;
    assign q12_prod = 13'(mon0) * 13'd43;
    assign q12 = q12_prod[12:9];

    always_comb begin
        if (mo == 7'd0) begin
            month = 4'd12;
            yoe = 9'd399 + 9'(yy);
        end else begin
            month = 4'(mon0 - 7'(q12) * 7'd12) + 4'd1;
            yoe = 9'd400 + 9'(yy) + 9'(q12) - ((month <= 4'd2) ? 9'd1 : 9'd0);
        end
    end

    assign tod = 19'(hh) * 19'd3600 + 19'(mi) * 19'd60 + 19'(ss);

    // Century years that are not leap years, counted from 1600 (2000 is a leap year).
    assign cent = (yoe2_reg >= 9'd500) ? 3'd4 : 3'd3;
    assign days_w = 20'(yoe2_reg) * 20'd365 + 20'(yoe2_reg[8:2]) - 20'(cent)
                  + 20'(doy2_reg) + 20'(dd2_reg) - 20'd135081;

    assign kmh_prod = 51'(prod2_reg[24:0]) * 51'(RecipSpeed);

    assign secs = 32'(days3_reg) * 32'd86400 + 32'(tod3_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else if (advance) begin
            v2_reg <= snap_valid;
            v3_reg <= v2_reg;
            vo_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            fix2_reg <= snap.fix;
            tod2_reg <= tod;
            yoe2_reg <= yoe;
            doy2_reg <= doy_of_month(month);
            dd2_reg <= dd;
            prod2_reg <= 34'(snap.speed_th) * 34'(scale);
            lat2_reg <= snap.lat;
            lon2_reg <= snap.lon;
            crs2_reg <= snap.course;

            fix3_reg <= fix2_reg;
            tod3_reg <= tod2_reg;
            days3_reg <= days_w[16:0];
            kmh3_reg <= (prod2_reg >= SpeedSatLimit) ? 8'd255 : kmh_prod[49:42];
            lat3_reg <= lat2_reg;
            lon3_reg <= lon2_reg;
            crs3_reg <= crs2_reg;

            fixo_reg <= fix3_reg;
            utco_reg <= fix3_reg ? secs : 32'd0;
            lato_reg <= fix3_reg ? lat3_reg : '0;
            lono_reg <= fix3_reg ? lon3_reg : '0;
            kmho_reg <= fix3_reg ? kmh3_reg : 8'd0;
            crso_reg <= fix3_reg ? crs3_reg : 9'd0;
        end
    end

    assign out_valid = vo_reg;
    assign fix_valid = fixo_reg;
    assign utc_seconds = utco_reg;
    assign latitude_units = lato_reg;
    assign longitude_units = lono_reg;
    assign speed_kmh = kmho_reg;
    assign course_degrees = crso_reg;

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        vo_reg && !fixo_reg |-> utco_reg == 32'd0 && kmho_reg == 8'd0
                                && crso_reg == 9'd0 && lato_reg == '0 && lono_reg == '0)
        else $error("invalid fix carries data");
    a_pipe_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && v3_reg |=> vo_reg) else $error("result lost in pipeline");
    a_pipe_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(v2_reg) && $stable(v3_reg) && $stable(vo_reg))
        else $error("pipeline moved while stalled");

endmodule
